// ----- hdl/spq_pkg.sv -----
// shared types and constants for the stable priority queue
`timescale 1ns / 1ps

package spq_pkg;

    localparam int PRIO_W    = 11;
    localparam int TAG_W     = 16;
    localparam int OCC_W     = 5;
    localparam int CAPACITY_DEF = 16;

    localparam logic [PRIO_W-1:0] EMPTY_PRIO = 11'd2000;

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // one stored ticket
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry word;
    } t_cell_ctl;

endpackage

// ----- hdl/spq_cell.sv -----
// one slot of the sorted shift register
`timescale 1ns / 1ps

module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_valid,
    input  spq_pkg::t_entry    i_left,
    input  logic               i_left_keep,
    input  spq_pkg::t_entry    i_right,
    output spq_pkg::t_entry    o_entry,
    output logic               o_keep
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // entry stays put on insert when it sorts at or before the new word
    assign o_keep  = i_valid && (r_entry.prio <= i_ctl.word.prio);
    assign o_entry = r_entry;

    // insert shifts right behind the insertion point, removal shifts left
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && !o_keep) begin
            n_entry = i_left_keep ? i_ctl.word : i_left;
        end else if (i_ctl.rem) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- hdl/stable_priority_queue_unit.sv -----
// stable priority queue: a chain of sorted cells with a registered result
// the result strobe is registered and rises in the cycle after the word is accepted
// throughput: one insert or removal per cycle while busy is low; every cell updates in parallel
// busy is high only during reset and in the first cycle after reset, the receiver cannot stall
// reset clears the count and the result strobe; slot contents are not cleared
`timescale 1ns / 1ps

module stable_priority_queue_unit #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic                       i_func,
    input  logic [spq_pkg::PRIO_W-1:0] i_priority_req,
    input  logic [spq_pkg::TAG_W-1:0]  i_ticket_tag,
    output logic                       o_done,
    output logic [spq_pkg::PRIO_W-1:0] o_out_priority,
    output logic [spq_pkg::TAG_W-1:0]  o_out_tag,
    output logic [1:0]                 o_status,
    output logic [spq_pkg::OCC_W-1:0]  o_occupancy,
    output logic                       o_is_empty_flag
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic                r_busy;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_done;
    logic [PRIO_W-1:0]   r_prio;
    logic [TAG_W-1:0]    r_tag;
    t_status             r_status;
    logic [PRIO_W-1:0]   n_prio;
    logic [TAG_W-1:0]    n_tag;
    t_status             n_status;

    logic                acc;
    logic                is_full;
    logic                none_held;
    t_cell_ctl           ctl;
    t_entry              cell_entry [CAPACITY];
    logic                cell_keep  [CAPACITY];
    logic                cell_valid [CAPACITY];

    assign acc       = i_start && !o_busy;
    assign is_full   = (r_count == CW'(CAPACITY));
    assign none_held = (r_count == '0);

    // command for the cell row
    always_comb begin
        ctl.ins       = acc && (i_func == FUNC_INSERT) && !is_full;
        ctl.rem       = acc && (i_func == FUNC_REMOVE) && !none_held;
        ctl.word.prio = i_priority_req;
        ctl.word.tag  = i_ticket_tag;
    end

    // cell row, head at index zero
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign cell_valid[g] = (CW'(g) < r_count);
        if (g == 0) begin : g_head
            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_valid     (cell_valid[g]),
                .i_left      (cell_entry[g]),
                .i_left_keep (1'b1),
                .i_right     (cell_entry[(g + 1) % CAPACITY]),
                .o_entry     (cell_entry[g]),
                .o_keep      (cell_keep[g])
            );
        end else if (g == CAPACITY - 1) begin : g_tail
            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_valid     (cell_valid[g]),
                .i_left      (cell_entry[g - 1]),
                .i_left_keep (cell_keep[g - 1]),
                .i_right     (cell_entry[g]),
                .o_entry     (cell_entry[g]),
                .o_keep      (cell_keep[g])
            );
        end else begin : g_mid
            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_valid     (cell_valid[g]),
                .i_left      (cell_entry[g - 1]),
                .i_left_keep (cell_keep[g - 1]),
                .i_right     (cell_entry[g + 1]),
                .o_entry     (cell_entry[g]),
                .o_keep      (cell_keep[g])
            );
        end
    end

    // next count and result word
    always_comb begin
        n_count  = r_count;
        n_prio   = '0;
        n_tag    = '0;
        n_status = ST_OK;
        if (ctl.ins) begin
            n_count = r_count + 1'b1;
        end
        if (ctl.rem) begin
            n_count = r_count - 1'b1;
            n_prio  = cell_entry[0].prio;
            n_tag   = cell_entry[0].tag;
        end
        if (i_func == FUNC_INSERT && is_full) begin
            n_status = ST_FULL;
        end
        if (i_func == FUNC_REMOVE && none_held) begin
            n_status = ST_EMPTY;
            n_prio   = EMPTY_PRIO;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_busy  <= 1'b0;
            r_count <= n_count;
            r_done  <= acc;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_prio   <= n_prio;
            r_tag    <= n_tag;
            r_status <= n_status;
        end
    end

    assign o_busy          = r_busy;
    assign o_done          = r_done;
    assign o_out_priority  = r_prio;
    assign o_out_tag       = r_tag;
    assign o_status        = r_status;
    assign o_occupancy     = OCC_W'(r_count);
    assign o_is_empty_flag = none_held;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count above capacity");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> o_done)
        else $error("missing result strobe");

    a_rem_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_func == FUNC_REMOVE && !none_held)
            |=> (r_count == $past(r_count) - 1'b1 && r_status == ST_OK))
        else $error("removal did not shrink queue");
`endif

endmodule
